>>> rtl/mtc_pkg.sv
// Shared types and constants of the matrix chain order cost block.
package mtc_pkg;

    // Width of the dimension field on the input stream.
    localparam int IN_W = 16;
    // Width of a cost value; wide enough that no chain cost can overflow.
    localparam int CW = 56;
    // Width of the reported top-level split.
    localparam int RW = 7;
    // Width of the status code.
    localparam int SW = 2;

    typedef enum logic [SW-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    // Shift controls of the dimension ring.
    typedef struct packed {
        logic shift_dn;
        logic shift_up;
    } t_ring_ctl;

    // Control word that travels with one split evaluation.
    typedef struct packed {
        logic valid;
        logic first;
        logic desc;
        logic zero_a;
        logic zero_b;
    } t_eval_ctl;

endpackage

>>> rtl/matrix_chain_order_cost.sv
// Top level of the matrix chain order cost block: loading, sequencing and result.
//
//  Channel  | Direction | Payload
//  ---------+-----------+--------------------------------------------------------
//  s_axis   | in        | tdata[15:0] dimension, tlast marks the final dimension
//  m_axis   | out       | tdata[55:0] min_cost, [62:56] root_split; tuser status
//
// Loading takes one word per cycle. After the last word, each pair (i, j) of the
// table takes two dimension reads, an alignment of the head, len - 1 split
// evaluations, a drain of the pipeline and one table write; the single split
// evaluation pipeline sets the pace, and the ring head must also move to the
// start of each new length. Reset is synchronous and active low and needs no
// clearing pass. Input is taken only while loading; a finished result waits in
// the output register while the next chain loads.
module matrix_chain_order_cost #(
    parameter int MAX_MATRICES = 64,
    parameter int DIM_WIDTH    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // Bits 15:0 dimension.
    input  logic [mtc_pkg::IN_W-1:0] i_s_axis_tdata,
    input  logic                     i_s_axis_tlast,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // Bits 55:0 min_cost, 62:56 root_split, 63 zero.
    output logic [63:0]              o_m_axis_tdata,
    // Bits 1:0 status.
    output logic [mtc_pkg::SW-1:0]   o_m_axis_tuser
);

    localparam int D    = MAX_MATRICES + 1;
    localparam int IW   = $clog2(MAX_MATRICES + 1);
    localparam int AW   = $clog2(MAX_MATRICES);
    localparam int CNTW = $clog2(MAX_MATRICES + 2);
    localparam int CAW  = 2 * AW;
    localparam int DW   = DIM_WIDTH;
    localparam int CW   = mtc_pkg::CW;
    localparam int RW   = mtc_pkg::RW;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b00000001,
        S_RDL   = 8'b00000010,
        S_RDR   = 8'b00000100,
        S_ALIGN = 8'b00001000,
        S_EVAL  = 8'b00010000,
        S_DRAIN = 8'b00100000,
        S_WRITE = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNTW-1:0]  r_cnt;
    logic             r_ovf;
    logic [IW-1:0]    r_n, r_len, r_i, r_h;
    logic             r_desc;
    logic [DW-1:0]    r_pl, r_pr;
    logic [CW-1:0]    r_res_cost, r_out_cost;
    logic [RW-1:0]    r_res_root, r_out_root;
    mtc_pkg::t_status r_res_status, r_out_status;
    logic             r_out_valid;

    logic             w_accept, w_store, w_ovf_next, w_out_load;
    logic [CNTW-1:0]  w_m;
    logic [IW:0]      w_j_wide;
    logic [IW-1:0]    w_j, w_jm1, w_im1, w_hm1, w_kstart, w_n_new;
    logic             w_at_start, w_k_last;
    logic [DW-1:0]    w_dim [D];
    logic [DW-1:0]    w_top_in, w_pl_rd;
    logic [CW-1:0]    w_cost_a, w_cost_b, w_best;
    logic [IW-1:0]    w_best_k;
    logic             w_busy;
    mtc_pkg::t_ring_ctl w_ring;
    mtc_pkg::t_eval_ctl w_ectl;

    // Input handshake and the running dimension count.
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_store    = w_accept && (r_cnt < CNTW'(D));
    assign w_ovf_next = r_ovf || (w_accept && !w_store);
    assign w_m        = w_store ? r_cnt + 1'b1 : r_cnt;
    assign w_n_new    = IW'(w_m - 1'b1);

    // Pair indices: j = i + len - 1; the split index k is the ring head index.
    assign w_j_wide = {1'b0, r_i} + {1'b0, r_len} - 1'b1;
    assign w_j      = w_j_wide[IW-1:0];
    assign w_jm1    = w_j - 1'b1;
    assign w_im1    = r_i - 1'b1;
    assign w_hm1    = r_h - 1'b1;

    // Passes alternate in direction so the head moves one step between pairs of the same length.
    assign w_kstart   = r_desc ? w_jm1 : r_i;
    assign w_at_start = (r_h == w_kstart);
    assign w_k_last   = r_desc ? (r_h == r_i) : (r_h == w_jm1);

    // Ring control: loading rotates a new word in at the top; otherwise the head
    // walks toward the split that is needed.
    always_comb begin
        w_ring = '0;
        case (r_state)
            S_LOAD: begin
                w_ring.shift_dn = w_store;
            end
            S_RDL, S_RDR, S_ALIGN: begin
                w_ring.shift_dn = (r_h < w_kstart);
                w_ring.shift_up = (r_h > w_kstart);
            end
            S_EVAL: begin
                w_ring.shift_dn = !w_k_last && !r_desc;
                w_ring.shift_up = !w_k_last && r_desc;
            end
            default: begin
                w_ring = '0;
            end
        endcase
    end

    assign w_top_in = (r_state == S_LOAD) ? i_s_axis_tdata[DW-1:0] : w_dim[0];

    // The dimension ring; cell 0 is the head and holds p[r_h].
    for (genvar c = 0; c < D; c++) begin : g_ring
        mtc_dim_cell #(.DW(DW)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ring),
            .i_from_up ((c == D - 1) ? w_top_in : w_dim[(c + 1) % D]),
            .i_from_dn ((c == 0) ? w_dim[D - 1] : w_dim[(c + D - 1) % D]),
            .o_dim     (w_dim[c])
        );
    end

    // A second copy of the dimensions serves the two end points of each pair.
    mtc_ram #(.WIDTH(DW), .DEPTH(D)) u_dims (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_cnt[IW-1:0]),
        .i_wr_data (i_s_axis_tdata[DW-1:0]),
        .i_rd_addr ((r_state == S_RDL) ? w_im1 : w_j),
        .o_rd_data (w_pl_rd)
    );

    // Two copies of the cost table, one per read stream of the split loop.
    mtc_ram #(.WIDTH(CW), .DEPTH(2 ** CAW)) u_cost_a (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_WRITE),
        .i_wr_addr ({w_im1[AW-1:0], w_jm1[AW-1:0]}),
        .i_wr_data (w_best),
        .i_rd_addr ({w_im1[AW-1:0], w_hm1[AW-1:0]}),
        .o_rd_data (w_cost_a)
    );

    mtc_ram #(.WIDTH(CW), .DEPTH(2 ** CAW)) u_cost_b (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_WRITE),
        .i_wr_addr ({w_im1[AW-1:0], w_jm1[AW-1:0]}),
        .i_wr_data (w_best),
        .i_rd_addr ({r_h[AW-1:0], w_jm1[AW-1:0]}),
        .o_rd_data (w_cost_b)
    );

    always_comb begin
        w_ectl.valid  = (r_state == S_EVAL);
        w_ectl.first  = w_at_start;
        w_ectl.desc   = r_desc;
        w_ectl.zero_a = (r_h == r_i);
        w_ectl.zero_b = (r_h == w_jm1);
    end

    mtc_split_eval #(.DW(DW), .IW(IW)) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ectl),
        .i_k      (r_h),
        .i_pk     (w_dim[0]),
        .i_pl     (r_pl),
        .i_pr     (r_pr),
        .i_cost_a (w_cost_a),
        .i_cost_b (w_cost_b),
        .o_busy   (w_busy),
        .o_best   (w_best),
        .o_best_k (w_best_k)
    );

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    // Sequencer: load, then per pair read the end points, align the head,
    // stream the splits, drain the pipeline and write the table entry.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_s_axis_tlast) begin
                    n_state = (w_m < CNTW'(3)) ? S_DONE : S_RDL;
                end
            end
            S_RDL:   n_state = S_RDR;
            S_RDR:   n_state = S_ALIGN;
            S_ALIGN: n_state = w_at_start ? S_EVAL : S_ALIGN;
            S_EVAL:  n_state = w_k_last ? S_DRAIN : S_EVAL;
            S_DRAIN: n_state = w_busy ? S_DRAIN : S_WRITE;
            S_WRITE: n_state = ((w_j == r_n) && (r_len == r_n)) ? S_DONE : S_RDL;
            S_DONE:  n_state = w_out_load ? S_LOAD : S_DONE;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_h         <= '0;
            r_n         <= '0;
            r_len       <= '0;
            r_i         <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Head index follows the ring; loading counts it modulo the ring size.
            if (w_store) begin
                r_h <= (w_m == CNTW'(D)) ? '0 : w_m[IW-1:0];
            end else if (w_ring.shift_dn) begin
                r_h <= (r_h == IW'(D - 1)) ? '0 : r_h + 1'b1;
            end else if (w_ring.shift_up) begin
                r_h <= (r_h == '0) ? IW'(D - 1) : r_h - 1'b1;
            end
            if (r_state == S_LOAD && w_accept) begin
                r_cnt <= w_m;
                r_ovf <= w_ovf_next;
                if (i_s_axis_tlast) begin
                    r_n    <= w_n_new;
                    r_len  <= IW'(2);
                    r_i    <= IW'(1);
                    r_desc <= 1'b0;
                end
            end
            if (r_state == S_WRITE) begin
                r_desc <= !r_desc;
                if (w_j == r_n) begin
                    r_len <= r_len + 1'b1;
                    r_i   <= IW'(1);
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_cnt       <= '0;
                r_ovf       <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RDR) begin
            r_pl <= w_pl_rd;
        end
        if (r_state == S_ALIGN) begin
            r_pr <= w_pl_rd;
        end
        if (r_state == S_LOAD && w_accept && i_s_axis_tlast) begin
            r_res_cost <= '0;
            r_res_root <= '0;
            if (w_m < CNTW'(2)) begin
                r_res_status <= mtc_pkg::ST_SHORT;
            end else if (w_ovf_next) begin
                r_res_status <= mtc_pkg::ST_TRUNC;
            end else begin
                r_res_status <= mtc_pkg::ST_OK;
            end
        end
        if (r_state == S_WRITE && w_j == r_n && r_len == r_n) begin
            r_res_cost <= w_best;
            r_res_root <= RW'(w_best_k);
        end
        if (w_out_load) begin
            r_out_cost   <= r_res_cost;
            r_out_root   <= r_res_root;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_root, r_out_cost};
    assign o_m_axis_tuser  = r_out_status;

    // The head only evaluates splits inside the current pair.
    a_split_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_h >= r_i && r_h < w_j))
        else $error("split index outside the pair");

    // A table entry is written only after every candidate has been compared.
    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> !w_busy)
        else $error("table write while evaluations are in flight");

    // A chain that is too short reports a zero cost and split.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == mtc_pkg::ST_SHORT) |-> (o_m_axis_tdata == '0))
        else $error("short chain with nonzero result");

endmodule

>>> rtl/mtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/mtc_dim_cell.sv
// One cell of the dimension ring; it takes its value from either neighbor.
module mtc_dim_cell #(
    parameter int DW = 16
) (
    input  logic               i_clk,
    input  mtc_pkg::t_ring_ctl i_ctl,
    input  logic [DW-1:0]      i_from_up,
    input  logic [DW-1:0]      i_from_dn,
    output logic [DW-1:0]      o_dim
);

    logic [DW-1:0] r_dim;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_dn) begin
            r_dim <= i_from_up;
        end else if (i_ctl.shift_up) begin
            r_dim <= i_from_dn;
        end
    end

    assign o_dim = r_dim;

endmodule

>>> rtl/mtc_split_eval.sv
// Pipelined evaluation of one split candidate and the running minimum.
module mtc_split_eval #(
    parameter int DW = 16,
    parameter int IW = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mtc_pkg::t_eval_ctl     i_ctl,
    input  logic [IW-1:0]          i_k,
    input  logic [DW-1:0]          i_pk,
    input  logic [DW-1:0]          i_pl,
    input  logic [DW-1:0]          i_pr,
    input  logic [mtc_pkg::CW-1:0] i_cost_a,
    input  logic [mtc_pkg::CW-1:0] i_cost_b,
    output logic                   o_busy,
    output logic [mtc_pkg::CW-1:0] o_best,
    output logic [IW-1:0]          o_best_k
);

    localparam int PW2 = 2 * DW;
    localparam int PW3 = 3 * DW;

    mtc_pkg::t_eval_ctl     r_s1;
    logic [IW-1:0]          r_k1, r_k2, r_k3, r_k4;
    logic [DW-1:0]          r_pk1;
    logic                   r_v2, r_v3, r_v4;
    logic                   r_first2, r_first3, r_first4;
    logic                   r_desc2, r_desc3, r_desc4;
    logic [mtc_pkg::CW-1:0] r_sum2, r_sum3, r_q4;
    logic [PW2-1:0]         r_prod2;
    logic [PW3-1:0]         r_prod3;
    logic [mtc_pkg::CW-1:0] r_best;
    logic [IW-1:0]          r_best_k;
    logic [mtc_pkg::CW-1:0] w_a, w_b;
    logic                   w_take;

    // The diagonal of the table is zero and is never stored.
    assign w_a = r_s1.zero_a ? '0 : i_cost_a;
    assign w_b = r_s1.zero_b ? '0 : i_cost_b;

    // Descending passes keep the smallest split on a tie by taking equal values.
    assign w_take = r_first4 || (r_desc4 ? (r_q4 <= r_best) : (r_q4 < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_s1 <= i_ctl;
            r_v2 <= r_s1.valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1     <= i_k;
        r_pk1    <= i_pk;
        r_k2     <= r_k1;
        r_first2 <= r_s1.first;
        r_desc2  <= r_s1.desc;
        r_sum2   <= w_a + w_b;
        r_prod2  <= PW2'(i_pl) * PW2'(r_pk1);
        r_k3     <= r_k2;
        r_first3 <= r_first2;
        r_desc3  <= r_desc2;
        r_sum3   <= r_sum2;
        r_prod3  <= PW3'(r_prod2) * PW3'(i_pr);
        r_k4     <= r_k3;
        r_first4 <= r_first3;
        r_desc4  <= r_desc3;
        r_q4     <= r_sum3 + mtc_pkg::CW'(r_prod3);
        if (r_v4 && w_take) begin
            r_best   <= r_q4;
            r_best_k <= r_k4;
        end
    end

    assign o_busy   = r_s1.valid | r_v2 | r_v3 | r_v4;
    assign o_best   = r_best;
    assign o_best_k = r_best_k;

endmodule
